/* sv/sle_pkg.sv */
package sle_pkg;

  // field widths fixed by the item format
  localparam int KIND_W = 4;
  localparam int POS_W  = 9;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;

  // command kinds
  localparam logic [KIND_W-1:0] KIND_CREATE  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_DESTROY = 4'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 4'd2;
  localparam logic [KIND_W-1:0] KIND_GET     = 4'd3;
  localparam logic [KIND_W-1:0] KIND_LOCATE  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_PRIOR   = 4'd5;
  localparam logic [KIND_W-1:0] KIND_NEXT    = 4'd6;
  localparam logic [KIND_W-1:0] KIND_INSERT  = 4'd7;
  localparam logic [KIND_W-1:0] KIND_DELETE  = 4'd8;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD    = 2'd1;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

  // list bookkeeping update
  typedef enum logic [2:0] {
    LIST_KEEP,
    LIST_CREATE,
    LIST_DESTROY,
    LIST_CLEAR,
    LIST_INC,
    LIST_DEC
  } list_op_e;

  // controller -> datapath
  typedef struct packed {
    logic              cap;        // capture the incoming item
    logic              start;      // set up the element walk
    logic              run;        // walk active this cycle
    logic              fin;        // finish with a fixed status
    logic [STAT_W-1:0] fin_status;
    list_op_e          list_op;
    logic              ins_wr;     // write the new element at its slot
    logic              load_out;   // move result into the output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              exists;
    logic              pos_ok;     // 1 <= position <= length
    logic              ins_ok;     // 1 <= position <= length + 1
    logic              ins_at_end; // position == length + 1
    logic              full;
    logic              empty;
    logic              run_done;
    logic              out_free;
  } dp_stat_t;

endpackage

/* sv/sle_if.sv */
interface sle_cmd_if import sle_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [POS_W-1:0]         position;
  logic signed [VAL_W-1:0]  value;

  modport source (output valid, output kind, output position, output value, input ready);
  modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

interface sle_res_if import sle_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [VAL_W-1:0]  value_out;
  logic [POS_W-1:0]         found_position;
  logic [POS_W-1:0]         length_now;
  logic                     is_empty;

  modport source (output valid, output status, output value_out, output found_position,
                  output length_now, output is_empty, input ready);
  modport sink   (input valid, input status, input value_out, input found_position,
                  input length_now, input is_empty, output ready);
endinterface

/* sv/sle_ram.sv */
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/sle_ctrl.sv */
module sle_ctrl import sle_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  output logic     cmd_ready_o,
  input  dp_stat_t dp_stat_i,
  output dp_cmd_t  dp_cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RUN  = 3'd2;
  localparam logic [2:0] S_INSW = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_q, state_d;

  assign cmd_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    dp_cmd_o = '0;
    dp_cmd_o.list_op = LIST_KEEP;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          dp_cmd_o.cap = 1'b1;
          state_d      = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        if (dp_stat_i.kind > KIND_DELETE) begin
          dp_cmd_o.fin        = 1'b1;
          dp_cmd_o.fin_status = ST_BAD;
        end else if (dp_stat_i.kind == KIND_CREATE) begin
          dp_cmd_o.fin = 1'b1;
          if (dp_stat_i.exists) begin
            dp_cmd_o.fin_status = ST_ABSENT;
          end else begin
            dp_cmd_o.fin_status = ST_OK;
            dp_cmd_o.list_op    = LIST_CREATE;
          end
        end else if (!dp_stat_i.exists) begin
          dp_cmd_o.fin        = 1'b1;
          dp_cmd_o.fin_status = ST_ABSENT;
        end else begin
          case (dp_stat_i.kind)
            KIND_DESTROY: begin
              dp_cmd_o.fin        = 1'b1;
              dp_cmd_o.fin_status = ST_OK;
              dp_cmd_o.list_op    = LIST_DESTROY;
            end
            KIND_CLEAR: begin
              dp_cmd_o.fin        = 1'b1;
              dp_cmd_o.fin_status = ST_OK;
              dp_cmd_o.list_op    = LIST_CLEAR;
            end
            KIND_GET, KIND_DELETE: begin
              if (!dp_stat_i.pos_ok) begin
                dp_cmd_o.fin        = 1'b1;
                dp_cmd_o.fin_status = ST_BAD;
              end else begin
                dp_cmd_o.start = 1'b1;
                state_d        = S_RUN;
              end
            end
            KIND_LOCATE, KIND_PRIOR, KIND_NEXT: begin
              if (dp_stat_i.empty) begin
                dp_cmd_o.fin        = 1'b1;
                dp_cmd_o.fin_status = ST_BAD;
              end else begin
                dp_cmd_o.start = 1'b1;
                state_d        = S_RUN;
              end
            end
            KIND_INSERT: begin
              if (!dp_stat_i.ins_ok) begin
                dp_cmd_o.fin        = 1'b1;
                dp_cmd_o.fin_status = ST_BAD;
              end else if (dp_stat_i.full) begin
                dp_cmd_o.fin        = 1'b1;
                dp_cmd_o.fin_status = ST_FULL;
              end else if (dp_stat_i.ins_at_end) begin
                state_d = S_INSW;
              end else begin
                dp_cmd_o.start = 1'b1;
                state_d        = S_RUN;
              end
            end
            default: begin
              dp_cmd_o.fin        = 1'b1;
              dp_cmd_o.fin_status = ST_BAD;
            end
          endcase
        end
      end
      S_RUN: begin
        dp_cmd_o.run = 1'b1;
        if (dp_stat_i.run_done) begin
          if (dp_stat_i.kind == KIND_INSERT) begin
            state_d = S_INSW;
          end else begin
            state_d = S_DONE;
            if (dp_stat_i.kind == KIND_DELETE) begin
              dp_cmd_o.list_op = LIST_DEC;
            end
          end
        end
      end
      S_INSW: begin
        dp_cmd_o.ins_wr  = 1'b1;
        dp_cmd_o.list_op = LIST_INC;
        state_d          = S_DONE;
      end
      S_DONE: begin
        if (dp_stat_i.out_free) begin
          dp_cmd_o.load_out = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/sle_dp.sv */
module sle_dp import sle_pkg::*; #(
  parameter int DEPTH     = 256,
  parameter int ELEM_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 dp_cmd_i,
  output dp_stat_t                dp_stat_o,
  input  logic [KIND_W-1:0]       kind_i,
  input  logic [POS_W-1:0]        position_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [STAT_W-1:0]       status_o,
  output logic signed [VAL_W-1:0] value_out_o,
  output logic [POS_W-1:0]        found_position_o,
  output logic [POS_W-1:0]        length_now_o,
  output logic                    is_empty_o
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // captured item
  logic [KIND_W-1:0]    kind_q;
  logic [POS_W-1:0]     pos_q;
  logic [ELEM_BITS-1:0] val_q;

  // list bookkeeping
  logic [CNT_W-1:0]     cnt_q;
  logic                 exists_q;

  // element walk: read side and returning-data side
  logic [AW-1:0]        rd_ptr_q;
  logic [CNT_W-1:0]     rd_left_q;
  logic                 dir_up_q;
  logic                 first_pend_q;
  logic                 el_vld_q, el_last_q, el_first_q;
  logic [AW-1:0]        el_ptr_q;
  logic [ELEM_BITS-1:0] prev_q;
  logic                 pm_q;

  // result being built
  logic [STAT_W-1:0]    res_status_q;
  logic [ELEM_BITS-1:0] res_vout_q;
  logic [CNT_W-1:0]     res_fpos_q;

  // output register
  logic                 out_valid_q;
  logic [STAT_W-1:0]    out_status_q;
  logic [VAL_W-1:0]     out_vout_q;
  logic [POS_W-1:0]     out_fpos_q;
  logic [POS_W-1:0]     out_len_q;
  logic                 out_empty_q;

  logic [CMP_W-1:0]     pos_ext, cnt_ext;
  logic [AW-1:0]        pos_m1, cnt_m1;
  logic [CNT_W-1:0]     tail_len;
  logic                 is_scan, issue, ev, eq, hit;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [ELEM_BITS-1:0] ram_wdata, rdata;

  assign pos_ext  = CMP_W'(pos_q);
  assign cnt_ext  = CMP_W'(cnt_q);
  assign pos_m1   = AW'(pos_ext - CMP_W'(1));
  assign cnt_m1   = AW'(cnt_q - CNT_W'(1));
  assign tail_len = CNT_W'(cnt_ext - pos_ext + CMP_W'(1));
  assign is_scan  = (kind_q == KIND_LOCATE) || (kind_q == KIND_PRIOR) ||
                    (kind_q == KIND_NEXT);

  assign issue = dp_cmd_i.run && (rd_left_q != '0);
  assign ev    = dp_cmd_i.run && el_vld_q;
  assign eq    = (rdata == val_q);

  always_comb begin
    case (kind_q)
      KIND_LOCATE: hit = eq;
      KIND_PRIOR:  hit = eq && !el_first_q;
      KIND_NEXT:   hit = pm_q;
      default:     hit = 1'b0;
    endcase
  end

  always_comb begin
    dp_stat_o.kind       = kind_q;
    dp_stat_o.exists     = exists_q;
    dp_stat_o.pos_ok     = (pos_q != '0) && (pos_ext <= cnt_ext);
    dp_stat_o.ins_ok     = (pos_q != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
    dp_stat_o.ins_at_end = (pos_ext == cnt_ext + CMP_W'(1));
    dp_stat_o.full       = (cnt_q == CNT_W'(DEPTH));
    dp_stat_o.empty      = (cnt_q == '0);
    dp_stat_o.run_done   = el_vld_q && (el_last_q || hit);
    dp_stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  // insert moves each element up one slot, delete moves it down one slot
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = el_ptr_q - AW'(1);
    ram_wdata = rdata;
    if (dp_cmd_i.ins_wr) begin
      ram_we    = 1'b1;
      ram_waddr = pos_m1;
      ram_wdata = val_q;
    end else if (ev && (kind_q == KIND_INSERT)) begin
      ram_we    = 1'b1;
      ram_waddr = el_ptr_q + AW'(1);
    end else if (ev && (kind_q == KIND_DELETE) && !el_first_q) begin
      ram_we    = 1'b1;
    end
  end

  sle_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (issue),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  // payload registers
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.cap) begin
      kind_q <= kind_i;
      pos_q  <= position_i;
      val_q  <= ELEM_BITS'(value_i);
    end
    if (dp_cmd_i.start) begin
      case (kind_q)
        KIND_GET: begin
          rd_ptr_q <= pos_m1;
          dir_up_q <= 1'b1;
        end
        KIND_DELETE: begin
          rd_ptr_q <= pos_m1;
          dir_up_q <= 1'b1;
        end
        KIND_INSERT: begin
          rd_ptr_q <= cnt_m1;
          dir_up_q <= 1'b0;
        end
        default: begin
          rd_ptr_q <= '0;
          dir_up_q <= 1'b1;
        end
      endcase
    end else if (issue) begin
      rd_ptr_q <= dir_up_q ? rd_ptr_q + AW'(1) : rd_ptr_q - AW'(1);
    end
    el_ptr_q <= rd_ptr_q;
    if (ev) begin
      prev_q <= rdata;
    end

    if (dp_cmd_i.start) begin
      res_status_q <= is_scan ? ST_BAD : ST_OK;
      res_vout_q   <= '0;
      res_fpos_q   <= '0;
    end else if (dp_cmd_i.fin || dp_cmd_i.ins_wr) begin
      res_status_q <= dp_cmd_i.fin ? dp_cmd_i.fin_status : ST_OK;
      res_vout_q   <= '0;
      res_fpos_q   <= '0;
    end else if (ev) begin
      if (el_first_q && ((kind_q == KIND_GET) || (kind_q == KIND_DELETE))) begin
        res_vout_q <= rdata;
      end
      if (hit) begin
        res_status_q <= ST_OK;
        case (kind_q)
          KIND_LOCATE: res_fpos_q <= CNT_W'(el_ptr_q) + CNT_W'(1);
          KIND_PRIOR:  res_vout_q <= prev_q;
          default:     res_vout_q <= rdata;
        endcase
      end
    end

    if (dp_cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_vout_q   <= VAL_W'(res_vout_q);
      out_fpos_q   <= POS_W'(res_fpos_q);
      out_len_q    <= POS_W'(cnt_q);
      out_empty_q  <= (cnt_q == '0);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      exists_q     <= 1'b0;
      rd_left_q    <= '0;
      first_pend_q <= 1'b0;
      el_vld_q     <= 1'b0;
      el_last_q    <= 1'b0;
      el_first_q   <= 1'b0;
      pm_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      case (dp_cmd_i.list_op)
        LIST_CREATE: begin
          exists_q <= 1'b1;
          cnt_q    <= '0;
        end
        LIST_DESTROY: begin
          exists_q <= 1'b0;
          cnt_q    <= '0;
        end
        LIST_CLEAR: cnt_q <= '0;
        LIST_INC:   cnt_q <= cnt_q + CNT_W'(1);
        LIST_DEC:   cnt_q <= cnt_q - CNT_W'(1);
        default:    cnt_q <= cnt_q;
      endcase

      if (dp_cmd_i.start) begin
        case (kind_q)
          KIND_GET:                 rd_left_q <= CNT_W'(1);
          KIND_DELETE, KIND_INSERT: rd_left_q <= tail_len;
          default:                  rd_left_q <= cnt_q;
        endcase
        first_pend_q <= 1'b1;
        pm_q         <= 1'b0;
      end else begin
        if (issue) begin
          rd_left_q    <= rd_left_q - CNT_W'(1);
          first_pend_q <= 1'b0;
        end
        if (ev) begin
          pm_q <= eq;
        end
      end
      el_vld_q   <= issue;
      el_last_q  <= (rd_left_q == CNT_W'(1));
      el_first_q <= first_pend_q;

      if (dp_cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign value_out_o      = out_vout_q;
  assign found_position_o = out_fpos_q;
  assign length_now_o     = out_len_q;
  assign is_empty_o       = out_empty_q;

endmodule

/* sv/sequential_list_engine.sv */
// Ordered list of signed elements held in an on-chip RAM, positions from 1.
//
// Channels: cmd_i carries one command item (kind, position, value); res_o
// returns exactly one result item per command (status, value_out,
// found_position, length_now, is_empty). Both use valid/ready; an item moves
// on a rising edge with valid and ready high.
//
// Timing: one command is worked at a time. Create, destroy, clear and every
// rejected command give their result without walking the elements. Get reads
// one element. Locate, prior and next walk the stored elements one per cycle
// from the front and stop at the match. Insert and delete move the tail one
// element per cycle through the RAM's single read and single write port;
// insert then writes the new element, and an append skips the walk.
//
// Reset clears the list (not created, length zero); RAM contents are not
// cleared, only written slots are ever read. If the receiver stalls, the
// result sits in the output register and the next command is still taken;
// its own result then waits until the output register is free.
module sequential_list_engine import sle_pkg::*; #(
  parameter int DEPTH     = 256,
  parameter int ELEM_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  sle_cmd_if.sink  cmd_i,
  sle_res_if.source res_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     cmd_ready;

  // sequencing: decode, element walk, final insert write, hand-off
  sle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_ready),
    .dp_stat_i   (dp_stat),
    .dp_cmd_o    (dp_cmd)
  );

  // element store, length bookkeeping, compare and result registers
  sle_dp #(
    .DEPTH     (DEPTH),
    .ELEM_BITS (ELEM_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .dp_cmd_i         (dp_cmd),
    .dp_stat_o        (dp_stat),
    .kind_i           (cmd_i.kind),
    .position_i       (cmd_i.position),
    .value_i          (cmd_i.value),
    .out_ready_i      (res_o.ready),
    .out_valid_o      (res_o.valid),
    .status_o         (res_o.status),
    .value_out_o      (res_o.value_out),
    .found_position_o (res_o.found_position),
    .length_now_o     (res_o.length_now),
    .is_empty_o       (res_o.is_empty)
  );

  assign cmd_i.ready = cmd_ready;

  // a command in flight blocks the next one
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.valid && cmd_ready |=> !cmd_ready)
    else $error("second command taken while one is in flight");

  // never grow past capacity
  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.list_op == LIST_INC |-> !dp_stat.full)
    else $error("element added to a full list");

  // never shrink below zero
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.list_op == LIST_DEC |-> !dp_stat.empty)
    else $error("element removed from an empty list");

  // element walks only run on an existing list
  a_walk_needs_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.start |-> dp_stat.exists)
    else $error("element walk started with no list");

  // a waiting result is never overwritten
  a_no_result_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.load_out |-> dp_stat.out_free)
    else $error("result overwritten before it was taken");

endmodule

/* tb/sequential_list_engine_tb.sv */
module sequential_list_engine_tb import sle_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH   = 256;
  localparam int RANDOM_ITEMS = 1750;
  localparam int SETTLE_CYCLES = 300;   // longer than the slowest walk

  // kinds the block must turn away as bad
  localparam logic [KIND_W-1:0] KIND_UNKNOWN_LO = 4'd9;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN_HI = 4'd15;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } list_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] value_out;
    logic [POS_W-1:0]        found_position;
    logic [POS_W-1:0]        length_now;
    logic                    is_empty;
  } list_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sle_cmd_if cmd_if ();
  sle_res_if res_if ();

  // command side, driven on the rising edge
  logic                    snd_valid = 1'b0;
  logic [KIND_W-1:0]       snd_kind  = KIND_CREATE;
  logic [POS_W-1:0]        snd_pos   = '0;
  logic signed [VAL_W-1:0] snd_val   = '0;
  logic                    rcv_ready = 1'b0;

  assign cmd_if.valid    = snd_valid;
  assign cmd_if.kind     = snd_kind;
  assign cmd_if.position = snd_pos;
  assign cmd_if.value    = snd_val;
  assign res_if.ready    = rcv_ready;

  sequential_list_engine #(
    .DEPTH     (LIST_DEPTH),
    .ELEM_BITS (VAL_W)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  // shadow of the list: contents, length and whether it has been created
  logic signed [VAL_W-1:0] list_mem [LIST_DEPTH];
  int                      list_len = 0;
  bit                      list_on  = 1'b0;

  list_cmd_t    cmds_waiting[$];   // items not yet offered to the block
  list_result_t results_due[$];    // one per accepted item, oldest first

  int n_mismatch   = 0;
  int n_random     = 0;
  int snd_idle_pct = 22;
  int rcv_idle_pct = 68;

  // random session shape: how long the list should grow and for how many items
  int sess_target   = 10;
  int sess_ops_left = 40;
  int fills_done    = 0;

  // Apply one command to the shadow list and return the result it gives.
  function automatic list_result_t apply_list_cmd(input list_cmd_t c);
    list_result_t r;
    int p;
    int j;
    r = '0;
    r.status = ST_OK;
    p = int'(c.position);
    if (c.kind > KIND_DELETE) begin
      r.status = ST_BAD;
    end else if (c.kind == KIND_CREATE) begin
      if (list_on) begin
        r.status = ST_ABSENT;
      end else begin
        list_on  = 1'b1;
        list_len = 0;
      end
    end else if (!list_on) begin
      r.status = ST_ABSENT;
    end else begin
      case (c.kind)
        KIND_DESTROY: begin
          list_on  = 1'b0;
          list_len = 0;
        end
        KIND_CLEAR: list_len = 0;
        KIND_GET: begin
          if (p < 1 || p > list_len) r.status = ST_BAD;
          else r.value_out = list_mem[p-1];
        end
        KIND_LOCATE: begin
          r.status = ST_BAD;
          for (j = 0; j < list_len && r.status == ST_BAD; j++) begin
            if (list_mem[j] == c.value) begin
              r.status = ST_OK;
              r.found_position = POS_W'(j + 1);
            end
          end
        end
        KIND_PRIOR: begin
          // first match from position 2 on gives the element before it
          r.status = ST_BAD;
          for (j = 1; j < list_len && r.status == ST_BAD; j++) begin
            if (list_mem[j] == c.value) begin
              r.status = ST_OK;
              r.value_out = list_mem[j-1];
            end
          end
        end
        KIND_NEXT: begin
          // first match up to the one before last gives the element after it
          r.status = ST_BAD;
          for (j = 0; j + 1 < list_len && r.status == ST_BAD; j++) begin
            if (list_mem[j] == c.value) begin
              r.status = ST_OK;
              r.value_out = list_mem[j+1];
            end
          end
        end
        KIND_INSERT: begin
          // position is checked before fullness
          if (p < 1 || p > list_len + 1) begin
            r.status = ST_BAD;
          end else if (list_len >= LIST_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            for (j = list_len; j >= p; j--) list_mem[j] = list_mem[j-1];
            list_mem[p-1] = c.value;
            list_len++;
          end
        end
        default: begin
          if (p < 1 || p > list_len) begin
            r.status = ST_BAD;
          end else begin
            r.value_out = list_mem[p-1];
            for (j = p; j < list_len; j++) list_mem[j-1] = list_mem[j];
            list_len--;
          end
        end
      endcase
    end
    r.length_now = POS_W'(list_len);
    r.is_empty   = (list_len == 0);
    return r;
  endfunction

  // Mostly a legal position in 1..upper, sometimes just outside it or anywhere.
  function automatic logic [POS_W-1:0] pick_pos(input int upper);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 85 && upper > 0) return POS_W'($urandom_range(1, upper));
    else if (sel < 90) return '0;
    else if (sel < 95) return POS_W'(upper + 1);
    else return POS_W'($urandom_range(0, 511));
  endfunction

  // Small values repeat often, so searches see duplicates; extremes now and then.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return VAL_W'(int'($urandom_range(0, 6)) - 3);
      3:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Next random command. Sessions run create, a mix of edits and searches
  // around a target length, then clear or destroy; two sessions fill the list.
  function automatic list_cmd_t pick_list_cmd();
    list_cmd_t c;
    int roll;
    int ins_w;
    int del_w;
    c.kind     = KIND_GET;
    c.position = pick_pos(list_len);
    c.value    = pick_value();
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      // noise: any kind, any position
      c.kind     = KIND_W'($urandom_range(0, 15));
      c.position = POS_W'($urandom_range(0, 511));
      c.value    = $urandom;
    end else if (!list_on) begin
      c.kind = (roll < 10) ? KIND_W'($urandom_range(1, 8)) : KIND_CREATE;
    end else if (sess_ops_left == 0) begin
      c.kind = (roll < 50) ? KIND_CLEAR : KIND_DESTROY;
      if ((fills_done == 0 && n_random > 150) || (fills_done == 1 && n_random > 900)) begin
        sess_target   = LIST_DEPTH;
        sess_ops_left = 360;
        fills_done++;
      end else begin
        sess_target   = $urandom_range(0, 24);
        sess_ops_left = $urandom_range(20, 80);
      end
    end else begin
      sess_ops_left--;
      roll  = $urandom_range(0, 99);
      ins_w = (list_len < sess_target) ? ((sess_target == LIST_DEPTH) ? 90 : 45) : 12;
      del_w = (list_len > sess_target) ? 35 : 10;
      if (roll < ins_w) begin
        c.kind = KIND_INSERT;
        // filling appends mostly, which keeps the tail shifts short
        if (sess_target == LIST_DEPTH && $urandom_range(0, 9) != 0)
          c.position = POS_W'(list_len + 1);
        else
          c.position = pick_pos(list_len + 1);
      end else if (roll < ins_w + del_w) begin
        c.kind = KIND_DELETE;
      end else begin
        case ($urandom_range(0, 3))
          0:       c.kind = KIND_GET;
          1:       c.kind = KIND_LOCATE;
          2:       c.kind = KIND_PRIOR;
          default: c.kind = KIND_NEXT;
        endcase
        if (c.kind != KIND_GET && list_len > 0 && $urandom_range(0, 9) < 6)
          c.value = list_mem[$urandom_range(0, list_len - 1)];
      end
    end
    return c;
  endfunction

  function automatic void queue_cmd(input logic [KIND_W-1:0] kind,
                                    input logic [POS_W-1:0] position,
                                    input logic signed [VAL_W-1:0] value);
    list_cmd_t c;
    c.kind     = kind;
    c.position = position;
    c.value    = value;
    cmds_waiting.push_back(c);
  endfunction

  task automatic note_mismatch(input string what, input list_result_t want,
                               input list_result_t got);
    n_mismatch++;
    if (n_mismatch <= 10) begin
      $display("%0t: %s: expected st=%0d val=%0d pos=%0d len=%0d empty=%0b",
               $realtime, what, want.status, want.value_out, want.found_position,
               want.length_now, want.is_empty);
      $display("  got st=%0d val=%0d pos=%0d len=%0d empty=%0b",
               got.status, got.value_out, got.found_position, got.length_now,
               got.is_empty);
    end
  endtask

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Command driver: predicts on acceptance, then offers the next item or idles.
  always @(posedge clk_i) begin
    list_cmd_t cur;
    list_cmd_t nxt;
    if (!rst_ni) begin
      snd_valid <= 1'b0;
    end else begin
      if (snd_valid && cmd_if.ready) begin
        cur.kind     = snd_kind;
        cur.position = snd_pos;
        cur.value    = snd_val;
        results_due.push_back(apply_list_cmd(cur));
      end
      if (!snd_valid || cmd_if.ready) begin
        if (cmds_waiting.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
          nxt = cmds_waiting.pop_front();
          snd_valid <= 1'b1;
          snd_kind  <= nxt.kind;
          snd_pos   <= nxt.position;
          snd_val   <= nxt.value;
        end else begin
          snd_valid <= 1'b0;
        end
      end
    end
  end

  // Result side: random back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) rcv_ready <= 1'b0;
    else rcv_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // Result monitor: each accepted item against the oldest prediction
  always @(posedge clk_i) begin
    list_result_t want;
    list_result_t got;
    if (rst_ni && res_if.valid && rcv_ready) begin
      got.status         = res_if.status;
      got.value_out      = res_if.value_out;
      got.found_position = res_if.found_position;
      got.length_now     = res_if.length_now;
      got.is_empty       = res_if.is_empty;
      if (results_due.size() == 0) begin
        note_mismatch("result with none due", '0, got);
      end else begin
        want = results_due.pop_front();
        if (got.status !== want.status || got.value_out !== want.value_out ||
            got.found_position !== want.found_position ||
            got.length_now !== want.length_now || got.is_empty !== want.is_empty)
          note_mismatch("result differs", want, got);
      end
    end
  end

  // Stimulus
  initial begin
    wait (rst_ni);

    // directed: absent list, double create, bounds on an empty list
    queue_cmd(KIND_GET,     9'd1,   0);
    queue_cmd(KIND_DESTROY, 9'd0,   0);
    queue_cmd(KIND_CREATE,  9'd0,   0);
    queue_cmd(KIND_CREATE,  9'd0,   0);
    queue_cmd(KIND_GET,     9'd1,   0);
    queue_cmd(KIND_DELETE,  9'd1,   0);
    queue_cmd(KIND_LOCATE,  9'd0,   0);
    queue_cmd(KIND_INSERT,  9'd0,   5);
    queue_cmd(KIND_INSERT,  9'd2,   5);
    // build [min, -1, max, 0]
    queue_cmd(KIND_INSERT,  9'd1,   32'h7FFF_FFFF);
    queue_cmd(KIND_INSERT,  9'd1,   32'h8000_0000);
    queue_cmd(KIND_INSERT,  9'd3,   0);
    queue_cmd(KIND_INSERT,  9'd2,   -1);
    queue_cmd(KIND_INSERT,  9'd511, 5);
    queue_cmd(KIND_GET,     9'd4,   0);
    queue_cmd(KIND_LOCATE,  9'd0,   32'h7FFF_FFFF);
    queue_cmd(KIND_LOCATE,  9'd0,   12345);
    // prior and next with and without an answer: the first element has no prior, the last no next
    queue_cmd(KIND_PRIOR,   9'd0,   32'h8000_0000);
    queue_cmd(KIND_PRIOR,   9'd0,   32'h7FFF_FFFF);
    queue_cmd(KIND_NEXT,    9'd0,   0);
    queue_cmd(KIND_NEXT,    9'd0,   -1);
    queue_cmd(KIND_DELETE,  9'd1,   0);
    queue_cmd(KIND_DELETE,  9'd4,   0);
    queue_cmd(KIND_UNKNOWN_LO, 9'd1, 0);
    queue_cmd(KIND_UNKNOWN_HI, 9'd1, 0);
    queue_cmd(KIND_CLEAR,   9'd0,   0);
    queue_cmd(KIND_DESTROY, 9'd0,   0);

    // random: one item topped up at a time so choices follow the list's state
    while (n_random < RANDOM_ITEMS) begin
      @(negedge clk_i);
      if (cmds_waiting.size() == 0) begin
        cmds_waiting.push_back(pick_list_cmd());
        n_random++;
        if (n_random == RANDOM_ITEMS / 3) begin
          snd_idle_pct = 68;
          rcv_idle_pct = 22;
        end else if (n_random == 2 * RANDOM_ITEMS / 3) begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      end
    end

    while (cmds_waiting.size() != 0 || snd_valid || results_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (n_mismatch == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
